### hw/rtl/rbst_pkg.sv
package rbst_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int DIST_IBITS = 32;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int MAG_BITS   = DIST_IBITS - 1 + FRAC_BITS;  // saturated magnitude width
  localparam int DIST_BITS  = MAG_BITS + 2;                // signed, room for +/- infinity
  localparam int QUO_BITS   = DIFF_BITS + FRAC_BITS;       // full quotient width
  localparam int NUM_STAGES = QUO_BITS;                    // one quotient bit per stage
  localparam int LAT        = NUM_STAGES + 3;

  typedef logic signed [DIST_BITS-1:0] dist_t;

  localparam dist_t DIST_MAX = dist_t'((64'd1 << MAG_BITS) - 64'd1);
  localparam dist_t DIST_INF = dist_t'(64'd1 << MAG_BITS);

  // Divider state carried down the pipe for one slab distance.
  typedef struct packed {
    logic                neg;
    logic [QUO_BITS-1:0] num;  // shifted-out numerator bits, MSB first
    logic [DIFF_BITS:0]  rem;
    logic [COORD_BITS-1:0] den;
    logic [QUO_BITS-1:0] quo;
  } div_t;

  // Per-axis side info that rides along the divider.
  typedef struct packed {
    logic zero_dir;
    logic in_slab;
  } axis_t;

endpackage

### hw/rtl/rbst_div_stage.sv
module rbst_div_stage (
  input  rbst_pkg::div_t div_i,
  output rbst_pkg::div_t div_o
);

  logic [rbst_pkg::DIFF_BITS+1:0] trial;
  logic [rbst_pkg::DIFF_BITS+1:0] shifted;

  // restoring division, one quotient bit
  always_comb begin
    shifted = {div_i.rem, div_i.num[rbst_pkg::QUO_BITS-1]};
    trial   = shifted - {3'b000, div_i.den};
    div_o       = div_i;
    div_o.num   = {div_i.num[rbst_pkg::QUO_BITS-2:0], 1'b0};
    if (!trial[rbst_pkg::DIFF_BITS+1]) begin
      div_o.rem = trial[rbst_pkg::DIFF_BITS:0];
      div_o.quo = {div_i.quo[rbst_pkg::QUO_BITS-2:0], 1'b1};
    end else begin
      div_o.rem = shifted[rbst_pkg::DIFF_BITS:0];
      div_o.quo = {div_i.quo[rbst_pkg::QUO_BITS-2:0], 1'b0};
    end
  end

endmodule

### hw/rtl/rbst_axis_front.sv
module rbst_axis_front (
  input  logic signed [rbst_pkg::COORD_BITS-1:0] org,
  input  logic signed [rbst_pkg::COORD_BITS-1:0] dir,
  input  logic signed [rbst_pkg::COORD_BITS-1:0] lo,
  input  logic signed [rbst_pkg::COORD_BITS-1:0] hi,
  output rbst_pkg::div_t div_in,
  output rbst_pkg::div_t div_out,
  output rbst_pkg::axis_t info
);

  logic signed [rbst_pkg::DIFF_BITS-1:0] d_lo;
  logic signed [rbst_pkg::DIFF_BITS-1:0] d_hi;
  logic signed [rbst_pkg::DIFF_BITS-1:0] n_in;
  logic signed [rbst_pkg::DIFF_BITS-1:0] n_out;
  logic [rbst_pkg::COORD_BITS-1:0]       dmag;
  logic                                  dneg;

  function automatic rbst_pkg::div_t seed(input logic signed [rbst_pkg::DIFF_BITS-1:0] n,
                                          input logic dn,
                                          input logic [rbst_pkg::COORD_BITS-1:0] dm);
    rbst_pkg::div_t s;
    logic [rbst_pkg::DIFF_BITS-1:0] m;
    m = n[rbst_pkg::DIFF_BITS-1] ? rbst_pkg::DIFF_BITS'(-n) : rbst_pkg::DIFF_BITS'(n);
    s.neg = n[rbst_pkg::DIFF_BITS-1] ^ dn;
    s.num = {m, {rbst_pkg::FRAC_BITS{1'b0}}};
    s.rem = '0;
    s.den = dm;
    s.quo = '0;
    return s;
  endfunction

  always_comb begin
    d_lo  = {lo[rbst_pkg::COORD_BITS-1], lo} - {org[rbst_pkg::COORD_BITS-1], org};
    d_hi  = {hi[rbst_pkg::COORD_BITS-1], hi} - {org[rbst_pkg::COORD_BITS-1], org};
    dneg  = dir[rbst_pkg::COORD_BITS-1];
    dmag  = dneg ? rbst_pkg::COORD_BITS'(-dir) : rbst_pkg::COORD_BITS'(dir);
    n_in  = dneg ? d_hi : d_lo;
    n_out = dneg ? d_lo : d_hi;
    div_in  = seed(n_in, dneg, dmag);
    div_out = seed(n_out, dneg, dmag);
    info.zero_dir = (dir == '0);
    info.in_slab  = (lo <= org) && (org <= hi);
  end

endmodule

### hw/rtl/ray_box_slab_test.sv
// Pipeline from input word to result word: one input register, one stage per
//   quotient bit of the slab divider, one saturation stage and one compare
//   stage feeding the output register.
// Throughput: one word per cycle; a stall on the output freezes the whole pipe.
// Reset: synchronous active-low rst_n clears all valid bits; data needs no reset.
module ray_box_slab_test (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [rbst_pkg::COORD_BITS-1:0] in_origin_x,
  input  logic signed [rbst_pkg::COORD_BITS-1:0] in_origin_y,
  input  logic signed [rbst_pkg::COORD_BITS-1:0] in_origin_z,
  input  logic signed [rbst_pkg::COORD_BITS-1:0] in_dir_x,
  input  logic signed [rbst_pkg::COORD_BITS-1:0] in_dir_y,
  input  logic signed [rbst_pkg::COORD_BITS-1:0] in_dir_z,
  input  logic signed [rbst_pkg::COORD_BITS-1:0] in_box_lo_x,
  input  logic signed [rbst_pkg::COORD_BITS-1:0] in_box_hi_x,
  input  logic signed [rbst_pkg::COORD_BITS-1:0] in_box_lo_y,
  input  logic signed [rbst_pkg::COORD_BITS-1:0] in_box_hi_y,
  input  logic signed [rbst_pkg::COORD_BITS-1:0] in_box_lo_z,
  input  logic signed [rbst_pkg::COORD_BITS-1:0] in_box_hi_z,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   out_hit
);

  localparam int NS = rbst_pkg::NUM_STAGES;

  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // input register
  logic                                   v0_r;
  logic signed [rbst_pkg::COORD_BITS-1:0] org_r [3];
  logic signed [rbst_pkg::COORD_BITS-1:0] dir_r [3];
  logic signed [rbst_pkg::COORD_BITS-1:0] lo_r  [3];
  logic signed [rbst_pkg::COORD_BITS-1:0] hi_r  [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
    end
    if (adv) begin
      org_r[0] <= in_origin_x; org_r[1] <= in_origin_y; org_r[2] <= in_origin_z;
      dir_r[0] <= in_dir_x;    dir_r[1] <= in_dir_y;    dir_r[2] <= in_dir_z;
      lo_r[0]  <= in_box_lo_x; lo_r[1]  <= in_box_lo_y; lo_r[2]  <= in_box_lo_z;
      hi_r[0]  <= in_box_hi_x; hi_r[1]  <= in_box_hi_y; hi_r[2]  <= in_box_hi_z;
    end
  end

  // six dividers (entry/exit per axis), NS stages each
  rbst_pkg::div_t  seed_d [6];
  rbst_pkg::axis_t seed_i [3];
  rbst_pkg::div_t  pipe_r [NS][6];
  rbst_pkg::div_t  step_d [NS][6];
  rbst_pkg::axis_t info_r [NS][3];
  logic [NS-1:0]   vp_r;

  for (genvar a = 0; a < 3; a++) begin : g_front
    rbst_axis_front u_front (
      .org     (org_r[a]),
      .dir     (dir_r[a]),
      .lo      (lo_r[a]),
      .hi      (hi_r[a]),
      .div_in  (seed_d[2*a]),
      .div_out (seed_d[2*a+1]),
      .info    (seed_i[a])
    );
  end

  for (genvar s = 0; s < NS; s++) begin : g_stage
    for (genvar k = 0; k < 6; k++) begin : g_div
      if (s == 0) begin : g_first
        rbst_div_stage u_div (
          .div_i (seed_d[k]),
          .div_o (step_d[s][k])
        );
      end else begin : g_next
        rbst_div_stage u_div (
          .div_i (pipe_r[s-1][k]),
          .div_o (step_d[s][k])
        );
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= '0;
    end else if (adv) begin
      vp_r <= {vp_r[NS-2:0], v0_r};
    end
    if (adv) begin
      pipe_r    <= step_d;
      info_r[0] <= seed_i;
      for (int s = 1; s < NS; s++) info_r[s] <= info_r[s-1];
    end
  end

  // saturate and sign the distances
  logic            vs_r;
  rbst_pkg::dist_t tin_r [3];
  rbst_pkg::dist_t tout_r [3];
  logic            ax_ok_r;
  rbst_pkg::dist_t tin_nxt [3];
  rbst_pkg::dist_t tout_nxt [3];
  logic            ax_ok_nxt;

  function automatic rbst_pkg::dist_t to_dist(input rbst_pkg::div_t d);
    rbst_pkg::dist_t m;
    if (d.quo[rbst_pkg::QUO_BITS-1:rbst_pkg::MAG_BITS] != '0) begin
      m = rbst_pkg::DIST_MAX;
    end else begin
      m = rbst_pkg::dist_t'(d.quo[rbst_pkg::MAG_BITS-1:0]);
    end
    return d.neg ? -m : m;
  endfunction

  always_comb begin
    ax_ok_nxt = 1'b1;
    for (int a = 0; a < 3; a++) begin
      if (info_r[NS-1][a].zero_dir) begin
        tin_nxt[a]  = -rbst_pkg::DIST_INF;
        tout_nxt[a] = rbst_pkg::DIST_INF;
        if (!info_r[NS-1][a].in_slab) ax_ok_nxt = 1'b0;
      end else begin
        tin_nxt[a]  = to_dist(pipe_r[NS-1][2*a]);
        tout_nxt[a] = to_dist(pipe_r[NS-1][2*a+1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r <= 1'b0;
    end else if (adv) begin
      vs_r <= vp_r[NS-1];
    end
    if (adv) begin
      tin_r   <= tin_nxt;
      tout_r  <= tout_nxt;
      ax_ok_r <= ax_ok_nxt;
    end
  end

  // cross-axis compare into the output register
  logic hit_nxt;
  assign hit_nxt = ax_ok_r &&
                   !(tin_r[0] > tout_r[1] || tin_r[1] > tout_r[0] ||
                     tin_r[1] > tout_r[2] || tin_r[2] > tout_r[1] ||
                     tin_r[2] > tout_r[0] || tin_r[0] > tout_r[2]);

  logic out_valid_r;
  logic out_hit_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vs_r;
    end
    if (adv) begin
      out_hit_r <= hit_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;

  a_stall_holds_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hit))
    else $error("output word changed under stall");
  a_in_stall_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall not tied to output backpressure");
  a_zero_axis_outside_misses: assert property (@(posedge clk) disable iff (!rst_n)
    adv && info_r[NS-1][0].zero_dir && !info_r[NS-1][0].in_slab |=> !ax_ok_r)
    else $error("zero-direction axis outside slab did not force a miss");
  a_valid_flows: assert property (@(posedge clk) disable iff (!rst_n)
    adv && vs_r |=> out_valid)
    else $error("word lost between last stage and output");

endmodule
